// ===== rtl/fpsc_pkg.sv =====
// Shared types and constants for the binary64 scaling block.
package fpsc_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned AdjWidth    = 32;
  localparam int unsigned ExpWidth    = 11;
  localparam int unsigned FracWidth   = 52;
  localparam int unsigned ManWidth    = FracWidth + 1;
  // Working exponent: adjust range plus operand range, signed.
  localparam int unsigned WExpWidth   = AdjWidth + 2;
  localparam int unsigned LzcWidth    = 6;

  localparam logic [ExpWidth-1:0] ExpMax = '1;
  localparam logic [ValueWidth-1:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [ValueWidth-1:0] InfBits = 64'h7FF0_0000_0000_0000;
  localparam logic [ValueWidth-1:0] MaxBits = 64'h7FEF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    RndNearest = 2'd0,
    RndZero    = 2'd1,
    RndUp      = 2'd2,
    RndDown    = 2'd3
  } round_mode_e;

  typedef struct packed {
    logic [ValueWidth-1:0]      value;
    logic signed [AdjWidth-1:0] exponent_adjust;
  } operand_t;

  typedef struct packed {
    logic [ValueWidth-1:0] result;
    logic                  overflow;
    logic                  underflow;
    logic                  inexact;
    logic                  range_error;
  } result_t;

  // Operand after unpacking, passed from the first stage to the second.
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic [FracWidth-1:0]    frac;
    logic signed [WExpWidth-1:0] exp;
  } unpacked_t;

endpackage

// ===== rtl/fpsc_if.sv =====
// Valid/ready channel interface with a generic payload.
interface fpsc_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fpsc_unpack.sv =====
// First stage logic: classifies the operand, normalises a subnormal and adds the adjustment.
module fpsc_unpack (
  input  logic [fpsc_pkg::ValueWidth-1:0]        value_i,
  input  logic signed [fpsc_pkg::AdjWidth-1:0]   exponent_adjust_i,
  output fpsc_pkg::unpacked_t                    unpacked_o
);
  import fpsc_pkg::*;

  logic [ExpWidth-1:0]  expf;
  logic [FracWidth-1:0] frac;
  logic [LzcWidth-1:0]  lz;
  logic [FracWidth-1:0] norm_frac;
  logic signed [WExpWidth-1:0] base_exp;

  assign expf = value_i[ValueWidth-2 -: ExpWidth];
  assign frac = value_i[FracWidth-1:0];

  // Leading-zero count over the fraction field.
  always_comb begin
    lz = '0;
    for (int i = 0; i < FracWidth; i++) begin
      if (frac[i]) begin
        lz = LzcWidth'(FracWidth - 1 - i);
      end
    end
  end

  always_comb begin
    if (expf == '0) begin
      // Shift the leading one into the hidden position and drop it.
      norm_frac = (frac << (lz + 1'b1));
      base_exp  = -WExpWidth'(signed'({1'b0, lz}));
    end else begin
      norm_frac = frac;
      base_exp  = WExpWidth'(signed'({1'b0, expf}));
    end
  end

  assign unpacked_o.sign    = value_i[ValueWidth-1];
  assign unpacked_o.special = (expf == ExpMax) || (expf == '0 && frac == '0);
  assign unpacked_o.frac    = norm_frac;
  assign unpacked_o.exp     = base_exp + WExpWidth'(exponent_adjust_i);
endmodule

// ===== rtl/fpsc_round.sv =====
// Second stage logic: overflow saturation, subnormal rounding and flush to zero.
module fpsc_round (
  input  logic [fpsc_pkg::ValueWidth-1:0] value_i,
  input  fpsc_pkg::unpacked_t             unpacked_i,
  input  fpsc_pkg::round_mode_e           round_mode_i,
  output fpsc_pkg::result_t               result_o
);
  import fpsc_pkg::*;

  logic [ManWidth-1:0]   m;
  logic [5:0]            s;
  logic [2*ManWidth-1:0] wide;
  logic [ManWidth-1:0]   q;
  logic [ManWidth-1:0]   rem;
  logic                  half_bit;
  logic                  rest_nz;
  logic                  rem_nz;
  logic                  up;
  logic [ManWidth-1:0]   q_rnd;
  logic                  sign;

  assign sign = unpacked_i.sign;
  assign m    = {1'b1, unpacked_i.frac};
  // Shift amount 1 - e, only meaningful for e in -54..0.
  assign s    = 6'(1 - unpacked_i.exp);
  assign wide = {m, {ManWidth{1'b0}}} >> s;
  assign q    = wide[2*ManWidth-1 -: ManWidth];
  assign rem  = wide[ManWidth-1:0];
  assign half_bit = rem[ManWidth-1];
  assign rest_nz  = rem[ManWidth-2:0] != '0;
  assign rem_nz   = half_bit | rest_nz;

  always_comb begin
    unique case (round_mode_i)
      RndNearest: up = half_bit && (rest_nz || q[0]);
      RndUp:      up = rem_nz && !sign;
      RndDown:    up = rem_nz && sign;
      default:    up = 1'b0;
    endcase
  end

  assign q_rnd = q + ManWidth'(up);

  always_comb begin
    result_o = '{result: value_i, overflow: 1'b0, underflow: 1'b0,
                 inexact: 1'b0, range_error: 1'b0};
    if (!unpacked_i.special) begin
      if (unpacked_i.exp >= WExpWidth'(2047)) begin
        result_o.overflow    = 1'b1;
        result_o.inexact     = 1'b1;
        result_o.range_error = 1'b1;
        unique case (round_mode_i)
          RndZero: result_o.result = (sign ? SignBit : '0) | MaxBits;
          RndUp:   result_o.result = sign ? (SignBit | MaxBits) : InfBits;
          RndDown: result_o.result = sign ? (SignBit | InfBits) : MaxBits;
          default: result_o.result = (sign ? SignBit : '0) | InfBits;
        endcase
      end else if (unpacked_i.exp < -WExpWidth'(54)) begin
        result_o.result      = sign ? SignBit : '0;
        result_o.underflow   = 1'b1;
        result_o.inexact     = 1'b1;
        result_o.range_error = 1'b1;
      end else if (unpacked_i.exp <= 0) begin
        result_o.result      = {sign, 10'b0, q_rnd};
        result_o.inexact     = rem_nz;
        result_o.underflow   = rem_nz;
        result_o.range_error = q_rnd == '0;
      end else begin
        result_o.result = {sign, unpacked_i.exp[ExpWidth-1:0], unpacked_i.frac};
      end
    end
  end
endmodule

// ===== rtl/fp64_scale_by_power_of_two.sv =====
// Top level: binary64 scale by a power of two.
// An input transfer passes through the s1, s2 and output registers before the result is offered.
// Throughput: one item per cycle while out_if.ready holds; the unpack stage and the rounding stage
// are each one register deep and advance whenever the stage after them is empty or being drained.
// Reset: valid flags clear and the rounding mode returns to nearest even.
module fp64_scale_by_power_of_two (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  fpsc_if.sink                          in_if,
  fpsc_if.source                        out_if
);
  import fpsc_pkg::*;

  round_mode_e round_mode_q;

  logic                  s1_valid_q;
  logic [ValueWidth-1:0] s1_value_q;
  logic [AdjWidth-1:0]   s1_adj_q;
  unpacked_t             s1_unp;

  logic                  s2_valid_q;
  logic [ValueWidth-1:0] s2_value_q;
  unpacked_t             s2_unp_q;
  result_t               s2_res;

  logic                  out_valid_q;
  result_t               out_q;

  logic adv_out, adv_s2, adv_s1;

  assign adv_out = !out_valid_q || out_if.ready;
  assign adv_s2  = !s2_valid_q || adv_out;
  assign adv_s1  = !s1_valid_q || adv_s2;

  assign in_if.ready    = adv_s1;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  fpsc_unpack u_unpack (
    .value_i          (s1_value_q),
    .exponent_adjust_i(signed'(s1_adj_q)),
    .unpacked_o       (s1_unp)
  );

  fpsc_round u_round (
    .value_i     (s2_value_q),
    .unpacked_i  (s2_unp_q),
    .round_mode_i(round_mode_q),
    .result_o    (s2_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_mode_q <= RndNearest;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        round_mode_q <= round_mode_e'(cfg_wdata_i);
      end
      if (adv_s1) begin
        s1_valid_q <= in_if.valid;
      end
      if (adv_s2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && in_if.valid) begin
      s1_value_q <= in_if.payload.value;
      s1_adj_q   <= in_if.payload.exponent_adjust;
    end
    if (adv_s2 && s1_valid_q) begin
      s2_value_q <= s1_value_q;
      s2_unp_q   <= s1_unp;
    end
    if (adv_out && s2_valid_q) begin
      out_q <= s2_res;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");
  a_ovf_inx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow |-> out_q.inexact && out_q.range_error)
    else $error("overflow without inexact and range error");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.overflow && out_q.underflow))
    else $error("overflow and underflow together");
  a_pipe_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && adv_out |=> out_valid_q)
    else $error("second stage item lost");
endmodule

// ===== test/fp64_scale_by_power_of_two_test.sv =====
// Self-checking testbench for the binary64 power-of-two scaling block.
module fp64_scale_by_power_of_two_test;
  import fpsc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = RndNearest;

  fpsc_if #(.payload_t(operand_t)) in_if ();
  fpsc_if #(.payload_t(result_t)) out_if ();

  fp64_scale_by_power_of_two u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #10 clk_i = ~clk_i;

  operand_t    pending_ops[$];
  result_t     scaled_expected[$];
  round_mode_e mode_shadow = RndNearest;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 54;
  int unsigned error_count = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  function automatic result_t predict_scaled(operand_t op, round_mode_e mode);
    result_t r;
    logic [63:0] sign, frac, m, q, rem, half;
    logic [10:0] expf;
    longint e;
    int unsigned s;
    logic up;
    sign = op.value & SignBit;
    expf = op.value[62:52];
    frac = {12'd0, op.value[51:0]};
    r = '0;
    r.result = op.value;
    if (expf == ExpMax || (expf == 0 && frac == 0)) return r;
    if (expf == 0) begin
      e = 1;
      while (frac[52] == 1'b0) begin
        frac = frac << 1;
        e--;
      end
      frac[52] = 1'b0;
    end else begin
      e = expf;
    end
    e += longint'(op.exponent_adjust);
    if (e >= 2047) begin
      r.overflow = 1'b1; r.inexact = 1'b1; r.range_error = 1'b1;
      case (mode)
        RndZero: r.result = sign | MaxBits;
        RndUp:   r.result = sign != 0 ? (sign | MaxBits) : InfBits;
        RndDown: r.result = sign != 0 ? (sign | InfBits) : MaxBits;
        default: r.result = sign | InfBits;
      endcase
    end else if (e < -54) begin
      r.result = sign;
      r.underflow = 1'b1; r.inexact = 1'b1; r.range_error = 1'b1;
    end else if (e <= 0) begin
      m = frac | 64'h0010_0000_0000_0000;
      s = 32'(1 - e);
      q = m >> s;
      rem = m & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      case (mode)
        RndNearest: up = rem > half || (rem == half && q[0]);
        RndUp:      up = rem != 0 && sign == 0;
        RndDown:    up = rem != 0 && sign != 0;
        default:    up = 1'b0;
      endcase
      if (up) q++;
      r.result = sign | q;
      r.inexact = rem != 0;
      r.underflow = rem != 0;
      r.range_error = q == 0;
    end else begin
      r.result = sign | (64'(e) << 52) | frac[51:0];
    end
    return r;
  endfunction

  // Random operand, weighted towards the rounding and saturation boundaries.
  function automatic operand_t random_operand();
    operand_t op;
    logic [10:0] expf;
    logic [51:0] frac;
    int target;
    frac = 52'({$urandom, $urandom});
    if ($urandom_range(3) == 0) frac = frac >> $urandom_range(51);
    case ($urandom_range(9))
      0: expf = ExpMax;
      1, 2: expf = 0;
      default: expf = 11'($urandom_range(2046, 1));
    endcase
    if (expf == 0 && $urandom_range(5) == 0) frac = 0;
    op.value = {1'($urandom), expf, frac};
    case ($urandom_range(9))
      0: op.exponent_adjust = $urandom;
      1: op.exponent_adjust = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: op.exponent_adjust = $urandom_range(120) - 60;
      default: begin
        case ($urandom_range(3))
          0: target = $urandom_range(2050, 2040);
          1: target = $urandom_range(2046, 1) ;
          default: target = int'($urandom_range(62)) - 58;
        endcase
        op.exponent_adjust = target - ((expf == 0) ? 1 : int'(expf));
      end
    endcase
    return op;
  endfunction

  // Driver: offers queued operands and records the expected result of each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        scaled_expected.push_back(predict_scaled(in_if.payload, mode_shadow));
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.payload <= pending_ops.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // A long receiver hold-off, so that the pipeline fills and stalls its input.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (scaled_expected.size() == 0) begin
          $error("unexpected result %h", out_if.payload.result);
          error_count++;
        end else begin
          exp_r = scaled_expected.pop_front();
          if (out_if.payload.result !== exp_r.result) begin
            $error("result: expected %h actual %h", exp_r.result, out_if.payload.result);
            error_count++;
          end
          if (out_if.payload.overflow !== exp_r.overflow) begin
            $error("overflow: expected %b actual %b", exp_r.overflow,
                   out_if.payload.overflow);
            error_count++;
          end
          if (out_if.payload.underflow !== exp_r.underflow) begin
            $error("underflow: expected %b actual %b", exp_r.underflow,
                   out_if.payload.underflow);
            error_count++;
          end
          if (out_if.payload.inexact !== exp_r.inexact) begin
            $error("inexact: expected %b actual %b", exp_r.inexact, out_if.payload.inexact);
            error_count++;
          end
          if (out_if.payload.range_error !== exp_r.range_error) begin
            $error("range_error: expected %b actual %b", exp_r.range_error,
                   out_if.payload.range_error);
            error_count++;
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_if.valid || scaled_expected.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_round_mode(round_mode_e mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_shadow = mode;
  endtask

  task automatic push_op(logic [63:0] v, int adj);
    operand_t op;
    op.value = v;
    op.exponent_adjust = adj;
    pending_ops.push_back(op);
  endtask

  initial begin
    round_mode_e modes[5];
    modes = '{RndNearest, RndZero, RndUp, RndDown, RndNearest};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 54;
        recv_idle_pct = 37;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_round_mode(ph == 4 ? round_mode_e'($urandom_range(3)) : modes[ph]);
      if (ph == 0 || ph == 3) begin
        // Pass-through cases, extremes, overflow, deep underflow and subnormal rounding.
        push_op(64'h7FF8_0000_0000_0001, 5);
        push_op(64'hFFF0_0000_0000_0000, -5);
        push_op(64'h0000_0000_0000_0000, 100);
        push_op(64'h8000_0000_0000_0000, -100);
        push_op(64'h0000_0000_0000_0001, 0);
        push_op(64'h0000_0000_0000_0001, 1074);
        push_op(64'h800F_FFFF_FFFF_FFFF, 1);
        push_op(64'h3FF0_0000_0000_0000, 1023);
        push_op(64'h3FF0_0000_0000_0000, 1024);
        push_op(64'hBFF0_0000_0000_0000, 1024);
        push_op(64'h7FEF_FFFF_FFFF_FFFF, 1);
        push_op(64'h3FF0_0000_0000_0000, -1022);
        push_op(64'h3FF0_0000_0000_0000, -1023);
        push_op(64'h3FF8_0000_0000_0000, -1074);
        push_op(64'hBFF0_0000_0000_0000, -1075);
        push_op(64'h3FFF_FFFF_FFFF_FFFF, -1023);
        push_op(64'h3FF0_0000_0000_0000, -1077);
        push_op(64'h3FF0_0000_0000_0000, -1078);
        push_op(64'h3FF0_0000_0000_0000, 32'sh7FFF_FFFF);
        push_op(64'hFFEF_FFFF_FFFF_FFFF, 32'sh8000_0000);
        push_op(64'h0000_0000_0000_0001, 32'sh7FFF_FFFF);
        push_op(64'h7FEF_FFFF_FFFF_FFFF, 32'sh8000_0000);
      end
      for (int i = 0; i < 105; i++) pending_ops.push_back(random_operand());
      if (ph == 4) hold_req = 1'b1;
      wait_drained();
    end
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && scaled_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
